// ===== src/xcrc_pkg.sv =====
// Shared types, constants and the CRC byte update for the XMODEM-CRC block receiver.
`default_nettype none

package xcrc_pkg;

    // Payload sizes announced by SOH and STX headers
    localparam int unsigned SHORT_PAYLOAD = 128;
    localparam int unsigned LONG_PAYLOAD  = 1024;
    localparam int unsigned COUNT_W       = $clog2(LONG_PAYLOAD + 1);

    // Depth of the queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Link bytes
    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CR  = 8'h0D;
    localparam logic [7:0] B_LF  = 8'h0A;
    localparam logic [7:0] B_C   = 8'h43;

    // Sum of block number and its inverse in a sound header
    localparam logic [8:0] NUM_INV_SUM = 9'd255;

    // CRC-16/XMODEM generator
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Block verdicts
    localparam logic [1:0] VERDICT_COMMIT = 2'd0;
    localparam logic [1:0] VERDICT_DUP    = 2'd1;
    localparam logic [1:0] VERDICT_BADCRC = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_session;
    } t_in_item;

    typedef struct packed {
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       name_valid;
        logic [7:0] name_byte;
        logic       name_end;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       block_end;
        logic [1:0] block_verdict;
        logic       drop;
        logic       done_res;
    } t_out_item;

    // Byte class worked out by the front
    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic is_soh;
        logic is_stx;
        logic is_eot;
    } t_class;

    // Entry of the queue between front and back
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_session;
        t_class     cls;
    } t_q_item;

    typedef enum logic [7:0] {
        M_NAME    = 8'b0000_0001,
        M_HEADER  = 8'b0000_0010,
        M_NUMBER  = 8'b0000_0100,
        M_INVERSE = 8'b0000_1000,
        M_PAYLOAD = 8'b0001_0000,
        M_CRC_HI  = 8'b0010_0000,
        M_CRC_LO  = 8'b0100_0000,
        M_HALT    = 8'b1000_0000
    } t_mode;

    // Run one byte through CRC-16/XMODEM, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== src/xcrc_front.sv =====
// Front: accepts received bytes, classifies them and pushes them into the queue.
`default_nettype none

module xcrc_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  xcrc_pkg::t_in_item i_in_data,
    input  wire                i_q_full,
    output logic               o_q_push,
    output xcrc_pkg::t_q_item  o_q_item
);

    xcrc_pkg::t_class cls;

    // Classify the byte against the protocol characters
    always_comb begin
        cls.is_cr  = (i_in_data.rx_byte == xcrc_pkg::B_CR);
        cls.is_lf  = (i_in_data.rx_byte == xcrc_pkg::B_LF);
        cls.is_soh = (i_in_data.rx_byte == xcrc_pkg::B_SOH);
        cls.is_stx = (i_in_data.rx_byte == xcrc_pkg::B_STX);
        cls.is_eot = (i_in_data.rx_byte == xcrc_pkg::B_EOT);
    end

    // Hold off the sender only while the queue is full
    assign o_in_stall           = i_q_full;
    assign o_q_push             = i_in_valid && !i_q_full;
    assign o_q_item.rx_byte     = i_in_data.rx_byte;
    assign o_q_item.new_session = i_in_data.new_session;
    assign o_q_item.cls         = cls;

    // A transfer must never be pushed into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_q_push)
        else $error("front pushed into a full queue");

endmodule

`default_nettype wire

// ===== src/xcrc_queue.sv =====
// Short queue that decouples the front from the back.
`default_nettype none

module xcrc_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  xcrc_pkg::t_q_item   i_item,
    input  wire                 i_pop,
    output logic                o_full,
    output logic                o_valid,
    output xcrc_pkg::t_q_item   o_item
);

    xcrc_pkg::t_q_item                  r_slot [xcrc_pkg::Q_DEPTH];
    logic [xcrc_pkg::Q_PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [xcrc_pkg::Q_PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [xcrc_pkg::Q_CNT_W-1:0]       r_count, n_count;

    assign o_full  = (r_count == xcrc_pkg::Q_CNT_W'(xcrc_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == xcrc_pkg::Q_PTR_W'(xcrc_pkg::Q_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == xcrc_pkg::Q_PTR_W'(xcrc_pkg::Q_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + xcrc_pkg::Q_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - xcrc_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !i_pop)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= xcrc_pkg::Q_CNT_W'(xcrc_pkg::Q_DEPTH))
        else $error("queue occupancy beyond its depth");

endmodule

`default_nettype wire

// ===== src/xcrc_back.sv =====
// Back: protocol sequencer, CRC check and result register.
`default_nettype none

module xcrc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  xcrc_pkg::t_q_item   i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output xcrc_pkg::t_out_item o_out_data
);

    xcrc_pkg::t_mode                r_mode, n_mode;
    logic [xcrc_pkg::COUNT_W-1:0]   r_byte_count, n_byte_count;
    logic [xcrc_pkg::COUNT_W-1:0]   cnt_inc, size;
    logic                           r_long_block, n_long_block;
    logic [7:0]                     r_last_good, n_last_good;
    logic [7:0]                     r_hdr_num, n_hdr_num;
    logic [7:0]                     r_hdr_inv, n_hdr_inv;
    logic [15:0]                    r_crc, n_crc;
    logic [7:0]                     r_crc_hi, n_crc_hi;
    logic [7:0]                     r_held_byte, n_held_byte;
    logic                           r_held_cr, n_held_cr;
    logic                           r_held_valid, n_held_valid;
    logic                           r_out_valid;
    xcrc_pkg::t_out_item            r_out_data, res;
    logic [8:0]                     num_inv_sum;
    logic [7:0]                     b;

    // Take the next entry when the result register is free or being drained
    assign o_q_pop     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign b           = i_q_item.rx_byte;
    assign cnt_inc     = r_byte_count + xcrc_pkg::COUNT_W'(1);
    assign size        = r_long_block ? xcrc_pkg::COUNT_W'(xcrc_pkg::LONG_PAYLOAD)
                                      : xcrc_pkg::COUNT_W'(xcrc_pkg::SHORT_PAYLOAD);
    assign num_inv_sum = {1'b0, r_hdr_num} + {1'b0, r_hdr_inv};

    // Sequence the protocol one byte at a time
    always_comb begin
        n_mode       = r_mode;
        n_byte_count = r_byte_count;
        n_long_block = r_long_block;
        n_last_good  = r_last_good;
        n_hdr_num    = r_hdr_num;
        n_hdr_inv    = r_hdr_inv;
        n_crc        = r_crc;
        n_crc_hi     = r_crc_hi;
        n_held_byte  = r_held_byte;
        n_held_cr    = r_held_cr;
        n_held_valid = r_held_valid;
        res          = '0;
        if (o_q_pop) begin
            if (i_q_item.new_session) begin
                n_mode       = xcrc_pkg::M_NAME;
                n_byte_count = '0;
                n_long_block = 1'b0;
                n_last_good  = '0;
                n_hdr_num    = '0;
                n_hdr_inv    = '0;
                n_crc        = '0;
                n_crc_hi     = '0;
                n_held_byte  = '0;
                n_held_cr    = 1'b0;
                n_held_valid = 1'b0;
            end else begin
                unique case (r_mode)
                    xcrc_pkg::M_NAME: begin
                        if (r_held_valid && r_held_cr && i_q_item.cls.is_lf) begin
                            res.reply_valid = 1'b1;
                            res.reply_byte  = xcrc_pkg::B_C;
                            res.name_end    = 1'b1;
                            n_held_valid    = 1'b0;
                            n_held_byte     = '0;
                            n_held_cr       = 1'b0;
                            n_mode          = xcrc_pkg::M_HEADER;
                        end else begin
                            // Forward the held character, hold this one
                            res.name_valid = r_held_valid;
                            res.name_byte  = r_held_valid ? r_held_byte : 8'h00;
                            n_held_byte    = b;
                            n_held_cr      = i_q_item.cls.is_cr;
                            n_held_valid   = 1'b1;
                        end
                    end
                    xcrc_pkg::M_HEADER: begin
                        priority if (i_q_item.cls.is_eot) begin
                            res.reply_valid = 1'b1;
                            res.reply_byte  = xcrc_pkg::B_ACK;
                            res.done_res    = 1'b1;
                            n_mode          = xcrc_pkg::M_HALT;
                        end else if (i_q_item.cls.is_soh || i_q_item.cls.is_stx) begin
                            n_long_block = i_q_item.cls.is_stx;
                            n_byte_count = '0;
                            n_crc        = '0;
                            n_mode       = xcrc_pkg::M_NUMBER;
                        end else begin
                            res.drop = 1'b1;
                            n_mode   = xcrc_pkg::M_HALT;
                        end
                    end
                    xcrc_pkg::M_NUMBER: begin
                        n_hdr_num = b;
                        n_mode    = xcrc_pkg::M_INVERSE;
                    end
                    xcrc_pkg::M_INVERSE: begin
                        n_hdr_inv = b;
                        n_mode    = xcrc_pkg::M_PAYLOAD;
                    end
                    xcrc_pkg::M_PAYLOAD: begin
                        res.data_valid = 1'b1;
                        res.data_byte  = b;
                        n_crc          = xcrc_pkg::crc16_byte(r_crc, b);
                        n_byte_count   = cnt_inc;
                        if (cnt_inc >= size) begin
                            n_mode = xcrc_pkg::M_CRC_HI;
                        end
                    end
                    xcrc_pkg::M_CRC_HI: begin
                        n_crc_hi = b;
                        n_mode   = xcrc_pkg::M_CRC_LO;
                    end
                    xcrc_pkg::M_CRC_LO: begin
                        // Inverse first, then CRC, then the block number
                        priority if (num_inv_sum != xcrc_pkg::NUM_INV_SUM) begin
                            res.drop = 1'b1;
                            n_mode   = xcrc_pkg::M_HALT;
                        end else if ({r_crc_hi, b} != r_crc) begin
                            res.reply_valid   = 1'b1;
                            res.reply_byte    = xcrc_pkg::B_NAK;
                            res.block_end     = 1'b1;
                            res.block_verdict = xcrc_pkg::VERDICT_BADCRC;
                            n_mode            = xcrc_pkg::M_HEADER;
                        end else if (r_hdr_num == r_last_good) begin
                            res.reply_valid   = 1'b1;
                            res.reply_byte    = xcrc_pkg::B_ACK;
                            res.block_end     = 1'b1;
                            res.block_verdict = xcrc_pkg::VERDICT_DUP;
                            n_mode            = xcrc_pkg::M_HEADER;
                        end else if (r_hdr_num != r_last_good + 8'd1) begin
                            res.drop = 1'b1;
                            n_mode   = xcrc_pkg::M_HALT;
                        end else begin
                            n_last_good       = r_hdr_num;
                            res.reply_valid   = 1'b1;
                            res.reply_byte    = xcrc_pkg::B_ACK;
                            res.block_end     = 1'b1;
                            res.block_verdict = xcrc_pkg::VERDICT_COMMIT;
                            n_mode            = xcrc_pkg::M_HEADER;
                        end
                        n_byte_count = '0;
                    end
                    xcrc_pkg::M_HALT: begin
                        n_mode = xcrc_pkg::M_HALT;
                    end
                    default: begin
                        n_mode = xcrc_pkg::M_HALT;
                    end
                endcase
            end
        end
    end

    // Protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= xcrc_pkg::M_NAME;
            r_byte_count <= '0;
            r_long_block <= 1'b0;
            r_last_good  <= '0;
            r_hdr_num    <= '0;
            r_hdr_inv    <= '0;
            r_crc        <= '0;
            r_crc_hi     <= '0;
            r_held_byte  <= '0;
            r_held_cr    <= 1'b0;
            r_held_valid <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_byte_count <= n_byte_count;
            r_long_block <= n_long_block;
            r_last_good  <= n_last_good;
            r_hdr_num    <= n_hdr_num;
            r_hdr_inv    <= n_hdr_inv;
            r_crc        <= n_crc;
            r_crc_hi     <= n_crc_hi;
            r_held_byte  <= n_held_byte;
            r_held_cr    <= n_held_cr;
            r_held_valid <= n_held_valid;
        end
    end

    // Result register: load on a pop, drop the valid once the transfer is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_data <= res;
        end
    end

    a_verdict_has_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.block_end) |-> r_out_data.reply_valid)
        else $error("block verdict without a reply");

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.drop) |-> (!r_out_data.reply_valid && !r_out_data.block_end))
        else $error("session drop carried a reply or verdict");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= xcrc_pkg::COUNT_W'(xcrc_pkg::LONG_PAYLOAD))
        else $error("payload counter ran past the long block size");

endmodule

`default_nettype wire

// ===== src/xmodem_crc_block_receiver_top.sv =====
// Top level of the XMODEM-CRC block receiver: front, queue and back.
// Each received byte (or new_session request) yields exactly one result transfer.
// The block takes one byte per clock and sustains that rate as long as the result side
// keeps up; the combinational CRC-16 byte update and header sequencer in the back stage
// set that figure. A byte's result is registered twice on its way out: first in the
// two-entry queue, then in the result register. When the result side stalls, the queue
// and the result register hold up to three bytes between them, and the input stall
// rises once the queue is full.
// New_session returns the receiver to file-name collection and gives an all-zero result.
`default_nettype none

module xmodem_crc_block_receiver_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  xcrc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output xcrc_pkg::t_out_item o_out_data
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    xcrc_pkg::t_q_item q_in_item;
    xcrc_pkg::t_q_item q_out_item;

    xcrc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in_item)
    );

    xcrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    xcrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
